/* hw/rtl/tiller_to_unicycle_command_top_assert.svh */
// Assertion macros for the tiller to unicycle command block.
`ifndef TILLER_TO_UNICYCLE_COMMAND_TOP_ASSERT_SVH
`define TILLER_TO_UNICYCLE_COMMAND_TOP_ASSERT_SVH

// Implication checked every clock, off during reset.
`define TUC_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error(msg);

// Next-cycle implication checked every clock, off during reset.
`define TUC_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error(msg);

`endif

/* hw/rtl/tuc_pkg.sv */
package tuc_pkg;

  localparam int unsigned AngleFracBits = 9;
  localparam int unsigned AtanLen = 24;
  localparam int unsigned CordicW = 34;

  // atan(2^-i) in degrees, 16 fraction bits
  localparam logic [21:0] ATAN_DEG_Q16 [AtanLen] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833, 22'd917,
    22'd458, 22'd229, 22'd115, 22'd57, 22'd29, 22'd14, 22'd7, 22'd4, 22'd2,
    22'd1, 22'd0
  };

  // throttle codes
  localparam logic [1:0] THR_OFF = 2'd0;
  localparam logic [1:0] THR_FWD = 2'd1;

  // register indexes
  localparam logic [2:0] REG_LOW   = 3'd0;
  localparam logic [2:0] REG_HIGH  = 3'd1;
  localparam logic [2:0] REG_VMAX  = 3'd2;
  localparam logic [2:0] REG_WMAX  = 3'd3;
  localparam logic [2:0] REG_LEN   = 3'd4;

  typedef struct packed {
    logic right;
    logic enabled;
    logic reverse;
  } ctl_t;

endpackage

/* hw/rtl/tiller_to_unicycle_command_top.sv */
// Tiller to unicycle command mapper.
// Input stream s_axis: one transaction per ADC sample with a throttle code.
// Output stream m_axis: one drive command per accepted sample, in order.
// Configuration: plain write port (cfg_we, cfg_index, cfg_data); write only
// while the pipeline is empty. Registers: 0 low limit, 1 high limit,
// 2 top linear speed, 3 top angular speed, 4 wheelbase length.
// Pipeline: angle map through a pipelined restoring divider, a CORDIC with
// one stage per step, a pipelined radius divider and a pipelined rate
// divider, then a two-entry output skid. Throughput is one transaction per
// cycle while the skid has room, set by the one-bit-per-stage dividers and
// CORDIC.
// Reset clears all valid bits and loads the register defaults.
// When m_axis_tready is low the pipeline keeps moving until the two-entry
// skid is full; then the whole pipeline holds and s_axis_tready drops,
// so nothing is lost or repeated.
module tiller_to_unicycle_command_top #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [11:0] steer_reading, [13:12] throttle_code, [15:14] zero
  input  logic [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] linear_velocity, [31:16] angular_velocity, [47:32] steer_angle,
  // [63:48] turn_radius, [64] steering_right, [65] drive_enabled,
  // [66] rate_capped, [71:67] zero
  output logic [71:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int unsigned AF  = tuc_pkg::AngleFracBits;
  localparam int unsigned CW  = tuc_pkg::CordicW;
  localparam int unsigned NQA = 17;   // angle quotient bits (full*n/den < 2^16)
  localparam int unsigned NQR = 17;   // radius quotient bits (sat above 65535)
  localparam int unsigned NQW = 16;   // rate quotient bits (sat above 32767)
  localparam int unsigned ADW = 28 + NQA;
  localparam logic [15:0] FULL = 16'(90 << AF);

  logic [11:0] reg_low, reg_high;
  logic [15:0] reg_vmax, reg_wmax, reg_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_low <= '0; reg_high <= 12'hFFF;
      reg_vmax <= 16'd256; reg_wmax <= 16'd256; reg_len <= 16'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tuc_pkg::REG_LOW:  reg_low  <= cfg_data[11:0];
        tuc_pkg::REG_HIGH: reg_high <= cfg_data[11:0];
        tuc_pkg::REG_VMAX: reg_vmax <= cfg_data;
        tuc_pkg::REG_WMAX: reg_wmax <= cfg_data;
        tuc_pkg::REG_LEN:  reg_len  <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- global stall: pipeline advances when skid has room
  logic adv;
  logic [1:0] skid_cnt;
  assign adv = (skid_cnt < 2'd2);
  assign s_axis_tready = adv;

  // ---- stage A0: angle map setup
  logic        a_v;
  tuc_pkg::ctl_t a_ctl;
  logic [15:0] a_vspd;
  logic [1:0]  a_kind;   // 0 full, 1 zero, 2 divide right, 3 divide left
  logic [27:0] a_num;    // full*n + den/2
  logic [11:0] a_den;

  always_ff @(posedge clk) begin
    logic [11:0] r, mid, den, n;
    logic [1:0] code;
    r = s_axis_tdata[11:0];
    code = s_axis_tdata[13:12];
    mid = ((reg_high - reg_low) >> 1) + reg_low;
    den = '0; n = '0;
    if (rst) a_v <= 1'b0;
    else if (adv) a_v <= s_axis_tvalid;
    if (adv) begin
      a_ctl.enabled <= (code != tuc_pkg::THR_OFF);
      a_ctl.reverse <= (code != tuc_pkg::THR_OFF) && (code != tuc_pkg::THR_FWD);
      a_vspd <= (code != tuc_pkg::THR_OFF) ? reg_vmax : 16'd0;
      if (r > reg_high) begin
        a_kind <= 2'd0; a_ctl.right <= 1'b0;
      end else if (r < reg_low) begin
        a_kind <= 2'd0; a_ctl.right <= 1'b1;
      end else if (r <= mid) begin
        den = mid - reg_low; n = r - reg_low;
        a_ctl.right <= 1'b1;
        a_kind <= (den == 12'd0) ? 2'd1 : 2'd2;
      end else begin
        den = reg_high - mid; n = r - mid;
        a_ctl.right <= 1'b0;
        a_kind <= 2'd3;
      end
      a_num <= 28'(FULL) * 28'(n) + 28'(den >> 1);
      a_den <= den;
    end
  end

  // ---- angle divider: restoring, one quotient bit per stage
  logic        ad_v   [NQA+1];
  tuc_pkg::ctl_t ad_ctl [NQA+1];
  logic [15:0] ad_vspd [NQA+1];
  logic [1:0]  ad_kind [NQA+1];
  logic [27:0] ad_rem [NQA+1];
  logic [11:0] ad_den [NQA+1];
  logic [NQA-1:0] ad_q [NQA+1];

  assign ad_v[0] = a_v; assign ad_ctl[0] = a_ctl; assign ad_vspd[0] = a_vspd;
  assign ad_kind[0] = a_kind; assign ad_rem[0] = a_num; assign ad_den[0] = a_den;
  assign ad_q[0] = '0;

  for (genvar k = 0; k < NQA; k++) begin : g_adiv
    localparam int unsigned SH = NQA - 1 - k;
    always_ff @(posedge clk) begin
      logic [ADW-1:0] trial;
      trial = ADW'(ad_den[k]) << SH;
      if (rst) ad_v[k+1] <= 1'b0;
      else if (adv) ad_v[k+1] <= ad_v[k];
      if (adv) begin
        ad_ctl[k+1] <= ad_ctl[k]; ad_vspd[k+1] <= ad_vspd[k];
        ad_kind[k+1] <= ad_kind[k]; ad_den[k+1] <= ad_den[k];
        if (ADW'(ad_rem[k]) >= trial) begin
          ad_rem[k+1] <= ad_rem[k] - trial[27:0];
          ad_q[k+1] <= ad_q[k] | (NQA'(1) << SH);
        end else begin
          ad_rem[k+1] <= ad_rem[k];
          ad_q[k+1] <= ad_q[k];
        end
      end
    end
  end

  // ---- angle select stage
  logic        b_v;
  tuc_pkg::ctl_t b_ctl;
  logic [15:0] b_vspd, b_angle;
  always_ff @(posedge clk) begin
    if (rst) b_v <= 1'b0;
    else if (adv) b_v <= ad_v[NQA];
    if (adv) begin
      b_ctl <= ad_ctl[NQA]; b_vspd <= ad_vspd[NQA];
      unique case (ad_kind[NQA])
        2'd0: b_angle <= FULL;
        2'd1: b_angle <= 16'd0;
        2'd2: b_angle <= FULL - ad_q[NQA][15:0];
        default: b_angle <= ad_q[NQA][15:0];
      endcase
    end
  end

  // ---- CORDIC, one step per stage
  logic        c_v   [CORDIC_STEPS+1];
  tuc_pkg::ctl_t c_ctl [CORDIC_STEPS+1];
  logic [15:0] c_vspd [CORDIC_STEPS+1];
  logic [15:0] c_ang [CORDIC_STEPS+1];
  logic signed [CW-1:0] c_x [CORDIC_STEPS+1];
  logic signed [CW-1:0] c_y [CORDIC_STEPS+1];
  logic signed [24:0] c_z [CORDIC_STEPS+1];

  assign c_v[0] = b_v; assign c_ctl[0] = b_ctl; assign c_vspd[0] = b_vspd;
  assign c_ang[0] = b_angle;
  assign c_x[0] = CW'(268435456); assign c_y[0] = '0;
  assign c_z[0] = 25'(b_angle) <<< (16 - AF);

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    localparam int unsigned TI = (i < tuc_pkg::AtanLen) ? i : tuc_pkg::AtanLen - 1;
    localparam logic [24:0] AT = (i < tuc_pkg::AtanLen) ?
                                 25'(tuc_pkg::ATAN_DEG_Q16[TI]) : 25'd0;
    always_ff @(posedge clk) begin
      logic signed [CW-1:0] dx, dy;
      dx = c_y[i] >>> i;
      dy = c_x[i] >>> i;
      if (rst) c_v[i+1] <= 1'b0;
      else if (adv) c_v[i+1] <= c_v[i];
      if (adv) begin
        c_ctl[i+1] <= c_ctl[i]; c_vspd[i+1] <= c_vspd[i]; c_ang[i+1] <= c_ang[i];
        if (!c_z[i][24]) begin
          c_x[i+1] <= c_x[i] - dx; c_y[i+1] <= c_y[i] + dy;
          c_z[i+1] <= c_z[i] - $signed(AT);
        end else begin
          c_x[i+1] <= c_x[i] + dx; c_y[i+1] <= c_y[i] - dy;
          c_z[i+1] <= c_z[i] + $signed(AT);
        end
      end
    end
  end

  // ---- products stage 1: clamp x and y, multiply w*L, scale speed
  localparam int unsigned XW = CW - 1;
  logic        d_v;
  tuc_pkg::ctl_t d_ctl;
  logic [15:0] d_vspd, d_ang;
  logic [XW-1:0] d_ux, d_uy;
  logic [31:0] d_wl;
  logic [31:0] d_vs;   // speed*256
  always_ff @(posedge clk) begin
    if (rst) d_v <= 1'b0;
    else if (adv) d_v <= c_v[CORDIC_STEPS];
    if (adv) begin
      d_ctl <= c_ctl[CORDIC_STEPS]; d_vspd <= c_vspd[CORDIC_STEPS];
      d_ang <= c_ang[CORDIC_STEPS];
      d_ux <= c_x[CORDIC_STEPS][CW-1] ? '0 : c_x[CORDIC_STEPS][XW-1:0];
      d_uy <= c_y[CORDIC_STEPS][CW-1] ? '0 : c_y[CORDIC_STEPS][XW-1:0];
      d_wl <= 32'(reg_wmax) * 32'(reg_len);
      d_vs <= {8'd0, c_vspd[CORDIC_STEPS], 8'd0};
    end
  end

  // ---- products stage 2: cross products and radius numerator
  localparam int unsigned PW = 32 + XW;
  localparam int unsigned RNW = 17 + XW + 1;
  logic        e_v;
  tuc_pkg::ctl_t e_ctl;
  logic [15:0] e_vspd, e_ang;
  logic [XW-1:0] e_uy;
  logic [RNW-1:0] e_rnum;
  logic          e_capped;
  logic [PW-1:0] e_lhs, e_rhs;
  always_ff @(posedge clk) begin
    if (rst) e_v <= 1'b0;
    else if (adv) e_v <= d_v;
    if (adv) begin
      e_ctl <= d_ctl; e_vspd <= d_vspd; e_ang <= d_ang; e_uy <= d_uy;
      e_rnum <= (RNW'(reg_len) * RNW'(d_ux) << 1) + RNW'(d_uy);
      e_lhs <= PW'(d_wl) * PW'(d_ux);
      e_rhs <= PW'(d_vs) * PW'(d_uy);
    end
  end
  assign e_capped = 1'b0;

  logic        f_v;
  tuc_pkg::ctl_t f_ctl;
  logic [15:0] f_vspd, f_ang;
  logic [XW:0] f_den;
  logic [RNW-1:0] f_rnum;
  logic        f_capped;
  always_ff @(posedge clk) begin
    if (rst) f_v <= 1'b0;
    else if (adv) f_v <= e_v;
    if (adv) begin
      f_ctl <= e_ctl; f_vspd <= e_vspd; f_ang <= e_ang;
      f_den <= {e_uy, 1'b0}; f_rnum <= e_rnum;
      f_capped <= e_ctl.enabled && (e_ang != 16'd0) && (e_lhs <= e_rhs) && !e_capped;
    end
  end

  // ---- radius divider: 17 quotient bits, saturate above 65535
  localparam int unsigned RDW = RNW + NQR;
  logic        rd_v   [NQR+1];
  tuc_pkg::ctl_t rd_ctl [NQR+1];
  logic [15:0] rd_vspd [NQR+1];
  logic [15:0] rd_ang [NQR+1];
  logic        rd_cap [NQR+1];
  logic        rd_big [NQR+1];
  logic [RNW-1:0] rd_rem [NQR+1];
  logic [XW:0] rd_den [NQR+1];
  logic [NQR-1:0] rd_q [NQR+1];

  assign rd_v[0] = f_v; assign rd_ctl[0] = f_ctl; assign rd_vspd[0] = f_vspd;
  assign rd_ang[0] = f_ang; assign rd_cap[0] = f_capped; assign rd_rem[0] = f_rnum;
  assign rd_den[0] = f_den; assign rd_q[0] = '0;
  // quotient at or above 2^NQR means saturation
  assign rd_big[0] = (f_rnum >= (RNW'(f_den) << NQR)) || (f_den == '0);

  for (genvar k = 0; k < NQR; k++) begin : g_rdiv
    localparam int unsigned SH = NQR - 1 - k;
    always_ff @(posedge clk) begin
      logic [RDW-1:0] trial;
      trial = RDW'(rd_den[k]) << SH;
      if (rst) rd_v[k+1] <= 1'b0;
      else if (adv) rd_v[k+1] <= rd_v[k];
      if (adv) begin
        rd_ctl[k+1] <= rd_ctl[k]; rd_vspd[k+1] <= rd_vspd[k];
        rd_ang[k+1] <= rd_ang[k]; rd_cap[k+1] <= rd_cap[k];
        rd_big[k+1] <= rd_big[k]; rd_den[k+1] <= rd_den[k];
        if (!rd_big[k] && (RDW'(rd_rem[k]) >= trial)) begin
          rd_rem[k+1] <= rd_rem[k] - trial[RNW-1:0];
          rd_q[k+1] <= rd_q[k] | (NQR'(1) << SH);
        end else begin
          rd_rem[k+1] <= rd_rem[k];
          rd_q[k+1] <= rd_q[k];
        end
      end
    end
  end

  // ---- radius select and rate setup
  logic        g_v;
  tuc_pkg::ctl_t g_ctl;
  logic [15:0] g_vspd, g_ang, g_rad;
  logic        g_cap;
  always_ff @(posedge clk) begin
    if (rst) g_v <= 1'b0;
    else if (adv) g_v <= rd_v[NQR];
    if (adv) begin
      g_ctl <= rd_ctl[NQR]; g_vspd <= rd_vspd[NQR]; g_ang <= rd_ang[NQR];
      g_cap <= rd_cap[NQR];
      if (rd_ang[NQR] == 16'd0 || rd_big[NQR] || rd_q[NQR][NQR-1])
        g_rad <= 16'hFFFF;
      else
        g_rad <= rd_q[NQR][15:0];
    end
  end

  // ---- capped linear product and rate numerator
  logic        h_v;
  tuc_pkg::ctl_t h_ctl;
  logic [15:0] h_ang, h_rad;
  logic        h_cap;
  logic [14:0] h_vmag;
  logic [14:0] h_cvmag;
  logic [24:0] h_wnum;
  always_ff @(posedge clk) begin
    logic [31:0] p;
    logic [23:0] pr;
    logic [14:0] vs;
    p = 32'(reg_wmax) * 32'(g_rad) + 32'd128;
    pr = p[31:8];
    vs = (g_vspd > 16'd32767) ? 15'h7FFF : g_vspd[14:0];
    if (rst) h_v <= 1'b0;
    else if (adv) h_v <= g_v;
    if (adv) begin
      h_ctl <= g_ctl; h_ang <= g_ang; h_rad <= g_rad; h_cap <= g_cap;
      h_vmag <= vs;
      h_cvmag <= (pr > 24'd32767) ? 15'h7FFF : pr[14:0];
      h_wnum <= {1'b0, vs, 9'd0} + 25'(g_rad);
    end
  end

  // ---- rate divider: wnum / (2*radius), 16 quotient bits, sat at 32767
  localparam int unsigned WDW = 25 + NQW;
  logic        wd_v   [NQW+1];
  tuc_pkg::ctl_t wd_ctl [NQW+1];
  logic [15:0] wd_ang [NQW+1];
  logic [15:0] wd_rad [NQW+1];
  logic        wd_cap [NQW+1];
  logic [14:0] wd_vmag [NQW+1];
  logic [14:0] wd_cvmag [NQW+1];
  logic [24:0] wd_rem [NQW+1];
  logic [NQW-1:0] wd_q [NQW+1];

  assign wd_v[0] = h_v; assign wd_ctl[0] = h_ctl; assign wd_ang[0] = h_ang;
  assign wd_rad[0] = h_rad; assign wd_cap[0] = h_cap; assign wd_vmag[0] = h_vmag;
  assign wd_cvmag[0] = h_cvmag; assign wd_rem[0] = h_wnum; assign wd_q[0] = '0;

  for (genvar k = 0; k < NQW; k++) begin : g_wdiv
    localparam int unsigned SH = NQW - 1 - k;
    always_ff @(posedge clk) begin
      logic [WDW-1:0] trial;
      trial = WDW'({wd_rad[k], 1'b0}) << SH;
      if (rst) wd_v[k+1] <= 1'b0;
      else if (adv) wd_v[k+1] <= wd_v[k];
      if (adv) begin
        wd_ctl[k+1] <= wd_ctl[k]; wd_ang[k+1] <= wd_ang[k];
        wd_rad[k+1] <= wd_rad[k]; wd_cap[k+1] <= wd_cap[k];
        wd_vmag[k+1] <= wd_vmag[k]; wd_cvmag[k+1] <= wd_cvmag[k];
        if (wd_rad[k] != 16'd0 && (WDW'(wd_rem[k]) >= trial)) begin
          wd_rem[k+1] <= wd_rem[k] - trial[24:0];
          wd_q[k+1] <= wd_q[k] | (NQW'(1) << SH);
        end else begin
          wd_rem[k+1] <= wd_rem[k];
          wd_q[k+1] <= wd_q[k];
        end
      end
    end
  end

  // ---- final select and signs
  logic        o_v;
  logic [71:0] o_data;
  always_ff @(posedge clk) begin
    logic [14:0] vmag, wmag;
    logic [15:0] lin, angv;
    logic vneg, wneg;
    tuc_pkg::ctl_t c;
    c = wd_ctl[NQW];
    vmag = '0; wmag = '0;
    if (wd_ang[NQW] == 16'd0) begin
      vmag = wd_vmag[NQW];
    end else if (c.enabled) begin
      if (wd_cap[NQW]) begin
        wmag = (reg_wmax > 16'd32767) ? 15'h7FFF : reg_wmax[14:0];
        vmag = wd_cvmag[NQW];
      end else begin
        vmag = wd_vmag[NQW];
        if (wd_rad[NQW] == 16'd0 || wd_q[NQW] > 16'd32767) wmag = 15'h7FFF;
        else wmag = wd_q[NQW][14:0];
      end
    end
    vneg = c.reverse;
    wneg = c.reverse ? c.right : !c.right;
    lin  = vneg ? 16'(-{1'b0, vmag}) : {1'b0, vmag};
    angv = wneg ? 16'(-{1'b0, wmag}) : {1'b0, wmag};
    if (rst) o_v <= 1'b0;
    else if (adv) o_v <= wd_v[NQW];
    if (adv) begin
      o_data <= {5'd0, wd_cap[NQW], c.enabled, c.right, wd_rad[NQW],
                 wd_ang[NQW], angv, lin};
    end
  end

  // ---- output skid: two entries, fed by o_v when the pipe advances
  logic [71:0] sk0, sk1;
  logic push, pop;
  assign push = adv && o_v;
  assign pop  = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = (skid_cnt != 2'd0);
  assign m_axis_tdata  = sk0;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_cnt <= '0;
    end else begin
      skid_cnt <= skid_cnt + 2'(push) - 2'(pop);
    end
    if (pop) begin
      if (push && skid_cnt == 2'd1) sk0 <= o_data;
      else sk0 <= sk1;
      if (push && skid_cnt == 2'd2) sk1 <= o_data;
    end else if (push) begin
      if (skid_cnt == 2'd0) sk0 <= o_data;
      else sk1 <= o_data;
    end
  end

  // terms for the output checks
  logic out_stall, out_cap, out_cap_ok;
  assign out_stall  = m_axis_tvalid && !m_axis_tready;
  assign out_cap    = m_axis_tvalid && m_axis_tdata[66];
  assign out_cap_ok = m_axis_tdata[65] && (m_axis_tdata[47:32] != 16'd0);

`include "tiller_to_unicycle_command_top_assert.svh"

  `TUC_ASSERT_IMP(a_skid_bound, clk, rst, 1'b1, skid_cnt <= 2'd2, "skid overflow")
  `TUC_ASSERT_IMP(a_no_push_full, clk, rst, skid_cnt == 2'd2, !push, "push into full skid")
  `TUC_ASSERT_NEXT(a_hold_out, clk, rst, out_stall, $stable(m_axis_tdata), "output moved in stall")
  `TUC_ASSERT_IMP(a_cap_en, clk, rst, out_cap, out_cap_ok, "capped without drive or angle")

endmodule
